[hdl/kalman_angle_bias_filter_unit_assert.svh]
// Assertion macros shared by the Kalman angle and bias filter RTL.
`ifndef KALMAN_ANGLE_BIAS_FILTER_UNIT_ASSERT_SVH
`define KALMAN_ANGLE_BIAS_FILTER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KABF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KABF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/kabf_pkg.sv]
// Shared constants of the Kalman angle and bias filter.
package kabf_pkg;

  // Fixed point and width constants.
  localparam int unsigned FRAC_BITS      = 24;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned ANGLE_W        = 32;
  localparam int unsigned STEP_W         = 25;
  localparam int unsigned NOISE_W        = 31;
  localparam int unsigned IN_TDATA_W     = 96;
  localparam int unsigned OUT_TDATA_W    = 96;
  localparam logic [STEP_W-1:0] ONE_SECOND = 25'd16777216;

  // Configuration register indexes.
  localparam logic [1:0] REG_Q_ANGLE = 2'd0;
  localparam logic [1:0] REG_Q_BIAS  = 2'd1;
  localparam logic [1:0] REG_R_MEAS  = 2'd2;

  // Reset values of the noise registers.
  localparam logic [NOISE_W-1:0] Q_ANGLE_RST = 31'd16777;
  localparam logic [NOISE_W-1:0] Q_BIAS_RST  = 31'd50332;
  localparam logic [NOISE_W-1:0] R_MEAS_RST  = 31'd503316;

endpackage

[hdl/kalman_angle_bias_filter_unit.sv]
// Two-state Kalman filter for tilt angle and gyro bias, built on serial units.
//
// Each accepted request runs a predict and correct step on one shared bit-serial
// multiplier (one operand bit per cycle, MAG = max(DATA_WIDTH, 33) bits per
// product) and one restoring divider (one quotient bit per cycle, DATA_WIDTH + 24
// quotient bits per gain). A step takes ten products and two quotients. When the
// innovation variance is not positive both gains are zero and the divider is
// skipped.
// The block takes a new request only when idle; a finished result waits in the
// output register, so the next request may enter before it is taken. A step whose
// result finds the output register still full waits in its last cycle.
`include "kalman_angle_bias_filter_unit_assert.svh"

module kalman_angle_bias_filter_unit #(
  parameter int unsigned DATA_WIDTH = kabf_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input stream.
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // angle_measured [31:0], rate_measured [63:32], step_time [88:64], zeros above
  input  logic [kabf_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // Result stream.
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // angle_filtered [31:0], bias_estimate [63:32], rate_corrected [95:64]
  output logic [kabf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // Configuration write port.
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [kabf_pkg::NOISE_W-1:0]       cfg_data_i
);

  localparam int unsigned W    = DATA_WIDTH;
  localparam int unsigned MAG  = (W > 33) ? W : 33;
  localparam int unsigned OPW  = MAG + 1;
  localparam int unsigned PW   = 2 * MAG;
  localparam int unsigned XW   = (PW - kabf_pkg::FRAC_BITS > 64) ?
                                 PW - kabf_pkg::FRAC_BITS : 64;
  localparam int unsigned SW   = ((W > 31) ? W : 31) + 1;
  localparam int unsigned SSW  = SW + 1;
  localparam int unsigned DIVN = W + kabf_pkg::FRAC_BITS;
  localparam int unsigned CW   = $clog2(DIVN + 1);
  localparam int unsigned AW   = kabf_pkg::ANGLE_W;
  localparam int unsigned NW   = kabf_pkg::NOISE_W;
  localparam int unsigned TW   = kabf_pkg::STEP_W;

  localparam logic signed [65:0] WHI = (66'sd1 <<< (W - 1)) - 66'sd1;
  localparam logic signed [65:0] WLO = -WHI - 66'sd1;
  localparam logic signed [65:0] AHI = (66'sd1 <<< (AW - 1)) - 66'sd1;
  localparam logic signed [65:0] ALO = -AHI - 66'sd1;
  localparam logic [W-1:0]       KLIM = {1'b0, {(W - 1){1'b1}}};

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_MUL, S_MWB, S_DIV, S_DWB, S_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_ANG, OP_BBDT, OP_INNER, OP_QB, OP_DK0, OP_DK1,
    OP_K0Y, OP_K1Y, OP_AA, OP_AB, OP_BA, OP_BB
  } op_e;

  // Saturate a wide signed value to the angle width.
  function automatic logic signed [AW-1:0] sat_a_f(input logic signed [65:0] v);
    logic signed [65:0] c;
    c = (v > AHI) ? AHI : ((v < ALO) ? ALO : v);
    return c[AW-1:0];
  endfunction

  // Saturate a wide signed value to the covariance width.
  function automatic logic signed [W-1:0] sat_w_f(input logic signed [65:0] v);
    logic signed [65:0] c;
    c = (v > WHI) ? WHI : ((v < WLO) ? WLO : v);
    return c[W-1:0];
  endfunction

  // Magnitude of a multiplier operand.
  function automatic logic [MAG-1:0] mag_f(input logic signed [OPW-1:0] v);
    logic signed [OPW-1:0] n;
    n = v[OPW-1] ? -v : v;
    return n[MAG-1:0];
  endfunction

  state_e state_q;
  op_e    op_q;
  logic [CW-1:0] cnt_q;

  logic [NW-1:0] qa_q, qb_q, rm_q;
  logic signed [AW-1:0] angle_q, bias_q, rate_q, meas_q;
  logic [TW-1:0] dt_q;
  logic signed [W-1:0] aa_q, ab_q, ba_q, bb_q, inner_q, k0_q, k1_q, p00_q, p01_q;
  logic signed [AW:0] y_q;

  // Serial multiplier registers.
  logic [MAG-1:0] mul_a_q;
  logic [PW-1:0]  p_q;
  logic           neg_q;

  // Serial divider registers.
  logic [W-1:0]  num_q, quo_q;
  logic [SW-1:0] den_q;
  logic [SW-1:0] rem_q;
  logic          qovf_q, dneg_q;

  logic [kabf_pkg::OUT_TDATA_W-1:0] out_q;
  logic                             out_vld_q;

  // Input field decode, with the step time clamped to one second.
  logic signed [AW-1:0] in_meas, in_gyro;
  logic [TW-1:0]        in_dt_raw, in_dt;
  assign in_meas   = s_axis_tdata_i[AW-1:0];
  assign in_gyro   = s_axis_tdata_i[2*AW-1:AW];
  assign in_dt_raw = s_axis_tdata_i[2*AW+TW-1:2*AW];
  assign in_dt     = (in_dt_raw > kabf_pkg::ONE_SECOND) ? kabf_pkg::ONE_SECOND : in_dt_raw;

  // Innovation and innovation variance, taken while loading an operation.
  logic signed [AW:0]    y_d;
  logic signed [SSW-1:0] s_d;
  assign y_d = (AW + 1)'(meas_q) - (AW + 1)'(angle_q);
  assign s_d = SSW'(aa_q) + $signed(SSW'(rm_q));

  // Operand selection for the shared multiplier.
  logic signed [OPW-1:0] op_a, op_b;
  always_comb begin
    op_a = $signed(OPW'(dt_q));
    op_b = OPW'(rate_q);
    case (op_q)
      OP_ANG:   begin op_a = $signed(OPW'(dt_q)); op_b = OPW'(rate_q); end
      OP_BBDT:  begin op_a = $signed(OPW'(dt_q)); op_b = OPW'(bb_q); end
      OP_INNER: begin op_a = $signed(OPW'(dt_q)); op_b = OPW'(inner_q); end
      OP_QB:    begin op_a = $signed(OPW'(qb_q)); op_b = $signed(OPW'(dt_q)); end
      OP_K0Y:   begin op_a = OPW'(k0_q); op_b = OPW'(y_d); end
      OP_K1Y:   begin op_a = OPW'(k1_q); op_b = OPW'(y_q); end
      OP_AA:    begin op_a = OPW'(k0_q); op_b = OPW'(aa_q); end
      OP_AB:    begin op_a = OPW'(k0_q); op_b = OPW'(p01_q); end
      OP_BA:    begin op_a = OPW'(k1_q); op_b = OPW'(p00_q); end
      OP_BB:    begin op_a = OPW'(k1_q); op_b = OPW'(p01_q); end
      default:  begin op_a = $signed(OPW'(dt_q)); op_b = OPW'(rate_q); end
    endcase
  end

  // One shift-and-add step of the multiplier.
  logic [MAG:0]  mul_sum;
  logic [PW-1:0] p_d;
  assign mul_sum = {1'b0, p_q[PW-1:MAG]} + (p_q[0] ? {1'b0, mul_a_q} : '0);
  assign p_d     = {mul_sum, p_q[MAG-1:1]};

  // Product scaled down by the fraction bits, clipped and signed.
  logic [XW-1:0]        prx, capx;
  logic [62:0]          mres;
  logic signed [63:0]   msig;
  assign prx  = XW'(p_q >> kabf_pkg::FRAC_BITS);
  assign capx = XW'(1) << 62;
  assign mres = (prx > capx) ? capx[62:0] : prx[62:0];
  assign msig = neg_q ? -$signed({1'b0, mres}) : $signed({1'b0, mres});

  // One restoring step of the divider.
  logic [SW:0]  rem_sh;
  logic         qbit;
  logic [SW:0]  rem_sub;
  assign rem_sh  = {rem_q, num_q[W-1]};
  assign qbit    = (rem_sh >= {1'b0, den_q});
  assign rem_sub = qbit ? (rem_sh - {1'b0, den_q}) : rem_sh;

  // Gain from the finished quotient.
  logic [W-1:0]        kmag;
  logic signed [W-1:0] kval;
  assign kmag = (qovf_q || quo_q[W-1]) ? KLIM : quo_q;
  assign kval = dneg_q ? -$signed(kmag) : $signed(kmag);

  logic out_free;
  assign out_free = !out_vld_q || m_axis_tready_i;

  // Sequencer, state, serial units and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= OP_ANG;
      cnt_q     <= '0;
      qa_q      <= kabf_pkg::Q_ANGLE_RST;
      qb_q      <= kabf_pkg::Q_BIAS_RST;
      rm_q      <= kabf_pkg::R_MEAS_RST;
      angle_q   <= '0;
      bias_q    <= '0;
      aa_q      <= '0;
      ab_q      <= '0;
      ba_q      <= '0;
      bb_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          kabf_pkg::REG_Q_ANGLE: qa_q <= cfg_data_i;
          kabf_pkg::REG_Q_BIAS:  qb_q <= cfg_data_i;
          kabf_pkg::REG_R_MEAS:  rm_q <= cfg_data_i;
          default: ;
        endcase
      end
      // A taken result empties the register unless a new one replaces it.
      if (out_vld_q && m_axis_tready_i && state_q != S_OUT) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            meas_q  <= in_meas;
            dt_q    <= in_dt;
            rate_q  <= sat_a_f(66'(in_gyro) - 66'(bias_q));
            op_q    <= OP_ANG;
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          cnt_q <= '0;
          if (op_q == OP_DK0 || op_q == OP_DK1) begin
            rem_q  <= '0;
            quo_q  <= '0;
            qovf_q <= 1'b0;
            if (op_q == OP_DK1) begin
              num_q   <= ba_q[W-1] ? W'(-ba_q) : W'(ba_q);
              dneg_q  <= ba_q[W-1];
              state_q <= S_DIV;
            end else if (s_d > 0) begin
              den_q   <= s_d[SW-1:0];
              num_q   <= aa_q[W-1] ? W'(-aa_q) : W'(aa_q);
              dneg_q  <= aa_q[W-1];
              state_q <= S_DIV;
            end else begin
              k0_q    <= '0;
              k1_q    <= '0;
              op_q    <= OP_K0Y;
            end
          end else begin
            if (op_q == OP_K0Y) begin
              y_q <= y_d;
            end
            if (op_q == OP_AA) begin
              p00_q <= aa_q;
              p01_q <= ab_q;
            end
            mul_a_q <= mag_f(op_a);
            p_q     <= {MAG'(0), mag_f(op_b)};
            neg_q   <= op_a[OPW-1] ^ op_b[OPW-1];
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          p_q   <= p_d;
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(MAG - 1)) begin
            state_q <= S_MWB;
          end
        end
        S_MWB: begin
          state_q <= S_LOAD;
          case (op_q)
            OP_ANG: begin
              angle_q <= sat_a_f(66'(angle_q) + 66'(msig));
              op_q    <= OP_BBDT;
            end
            OP_BBDT: begin
              inner_q <= sat_w_f(66'(msig) - 66'(ab_q) - 66'(ba_q) + $signed(66'(qa_q)));
              ab_q    <= sat_w_f(66'(ab_q) - 66'(msig));
              ba_q    <= sat_w_f(66'(ba_q) - 66'(msig));
              op_q    <= OP_INNER;
            end
            OP_INNER: begin
              aa_q <= sat_w_f(66'(aa_q) + 66'(msig));
              op_q <= OP_QB;
            end
            OP_QB: begin
              bb_q <= sat_w_f(66'(bb_q) + 66'(msig));
              op_q <= OP_DK0;
            end
            OP_K0Y: begin
              angle_q <= sat_a_f(66'(angle_q) + 66'(msig));
              op_q    <= OP_K1Y;
            end
            OP_K1Y: begin
              bias_q <= sat_a_f(66'(bias_q) + 66'(msig));
              op_q   <= OP_AA;
            end
            OP_AA: begin
              aa_q <= sat_w_f(66'(aa_q) - 66'(msig));
              op_q <= OP_AB;
            end
            OP_AB: begin
              ab_q <= sat_w_f(66'(ab_q) - 66'(msig));
              op_q <= OP_BA;
            end
            OP_BA: begin
              ba_q <= sat_w_f(66'(ba_q) - 66'(msig));
              op_q <= OP_BB;
            end
            OP_BB: begin
              bb_q    <= sat_w_f(66'(bb_q) - 66'(msig));
              state_q <= S_OUT;
            end
            default: state_q <= S_IDLE;
          endcase
        end
        S_DIV: begin
          rem_q  <= rem_sub[SW-1:0];
          num_q  <= {num_q[W-2:0], 1'b0};
          quo_q  <= {quo_q[W-2:0], qbit};
          qovf_q <= qovf_q | quo_q[W-1];
          cnt_q  <= cnt_q + CW'(1);
          if (cnt_q == CW'(DIVN - 1)) begin
            state_q <= S_DWB;
          end
        end
        S_DWB: begin
          state_q <= S_LOAD;
          if (op_q == OP_DK0) begin
            k0_q <= kval;
            op_q <= OP_DK1;
          end else begin
            k1_q <= kval;
            op_q <= OP_K0Y;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_q     <= {rate_q, bias_q, angle_q};
            out_vld_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

  // A request starts a step, so the input side closes in the next cycle.
  `KABF_ASSERT_NXT(a_busy_after_req, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "input still open after request")
  // The multiplier never runs past its operand width.
  `KABF_ASSERT_IMP(a_mul_count, state_q == S_MUL, cnt_q < CW'(MAG), "multiplier count overrun")
  // A finished step posts its result and returns to idle.
  `KABF_ASSERT_NXT(a_out_post, state_q == S_OUT && out_free, m_axis_tvalid_o && state_q == S_IDLE, "result not posted")

endmodule

[test/testbench.sv]
// Self-checking testbench for the Kalman angle and gyro bias filter unit.
module testbench;

  localparam int CW       = 32;   // covariance width, DATA_WIDTH of the instance
  localparam int N_RANDOM = 1900;
  localparam longint LIMIT = 64'd10_000_000;

  typedef struct packed {
    logic [31:0] angle_meas;
    logic [31:0] rate_meas;
    logic [24:0] step;
  } req_t;

  typedef struct packed {
    logic [31:0] angle_filt;
    logic [31:0] bias_est;
    logic [31:0] rate_corr;
  } res_t;

  typedef struct {
    req_t        req;
    bit          has_known;
    res_t        known;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [kabf_pkg::IN_TDATA_W-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [kabf_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = kabf_pkg::REG_Q_ANGLE;
  logic [kabf_pkg::NOISE_W-1:0] cfg_data_i = '0;

  kalman_angle_bias_filter_unit #(.DATA_WIDTH(CW)) dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Filter state mirrored by the predictor.
  longint q_angle, q_bias, r_meas;
  longint est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;

  res_t   expected_results[$];
  int     mismatches = 0;
  longint cycles = 0;
  bit     hold_off = 1'b0;
  bit     stim_done = 1'b0;

  function automatic longint clip(longint v, int w);
    longint hi, lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // Product shifted down by the fraction bits, magnitude truncated, capped at 2^62.
  function automatic longint qmul(longint a, longint b);
    bit neg;
    logic [127:0] p;
    logic [127:0] r;
    neg = (a < 0) != (b < 0);
    p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
    r = p >> kabf_pkg::FRAC_BITS;
    if (r > (128'd1 << 62)) r = 128'd1 << 62;
    return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
  endfunction

  // Quotient with fraction bits, truncated and saturated to the covariance width.
  function automatic longint qdiv(longint num, longint den);
    logic [127:0] q;
    longint lim;
    lim = (64'sd1 <<< (CW - 1)) - 1;
    q = (128'(num < 0 ? -num : num) << kabf_pkg::FRAC_BITS) / 128'(den);
    if (q > 128'(lim)) q = 128'(lim);
    return num < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic void filter_reset();
    q_angle = kabf_pkg::Q_ANGLE_RST;
    q_bias = kabf_pkg::Q_BIAS_RST;
    r_meas = kabf_pkg::R_MEAS_RST;
    {est_angle, est_bias, p_aa, p_ab, p_ba, p_bb} = '0;
  endfunction

  // One predict and correct step of the filter.
  function automatic res_t filter_step(req_t rq);
    longint dt, rate, inner, s, k0, k1, y, c_aa, c_ab;
    res_t r;
    dt = (rq.step > kabf_pkg::ONE_SECOND) ? longint'(kabf_pkg::ONE_SECOND)
                                          : longint'(rq.step);
    rate = clip(longint'($signed(rq.rate_meas)) - est_bias, 32);
    est_angle = clip(est_angle + qmul(dt, rate), 32);
    inner = clip(qmul(dt, p_bb) - p_ab - p_ba + q_angle, CW);
    p_aa = clip(p_aa + qmul(dt, inner), CW);
    p_ab = clip(p_ab - qmul(dt, p_bb), CW);
    p_ba = clip(p_ba - qmul(dt, p_bb), CW);
    p_bb = clip(p_bb + qmul(q_bias, dt), CW);
    s = p_aa + r_meas;
    k0 = 0;
    k1 = 0;
    if (s > 0) begin
      k0 = qdiv(p_aa, s);
      k1 = qdiv(p_ba, s);
    end
    y = longint'($signed(rq.angle_meas)) - est_angle;
    est_angle = clip(est_angle + qmul(k0, y), 32);
    est_bias = clip(est_bias + qmul(k1, y), 32);
    c_aa = p_aa;
    c_ab = p_ab;
    p_aa = clip(p_aa - qmul(k0, c_aa), CW);
    p_ab = clip(p_ab - qmul(k0, c_ab), CW);
    p_ba = clip(p_ba - qmul(k1, c_aa), CW);
    p_bb = clip(p_bb - qmul(k1, c_ab), CW);
    r.angle_filt = est_angle[31:0];
    r.bias_est = est_bias[31:0];
    r.rate_corr = rate[31:0];
    return r;
  endfunction

  function automatic req_t rand_req();
    req_t rq;
    int   mode;
    mode = $urandom_range(0, 9);
    rq.angle_meas = (mode == 0) ? $urandom : 32'($signed($urandom_range(0, 12_000_000))
                    - 6_000_000);
    rq.rate_meas = (mode == 1) ? $urandom : 32'($signed($urandom_range(0, 40_000_000))
                   - 20_000_000);
    case (mode)
      2: rq.step = 25'($urandom);
      3: rq.step = kabf_pkg::ONE_SECOND;
      default: rq.step = 25'($urandom_range(0, 400_000));
    endcase
    return rq;
  endfunction

  // Offer one request and return right after the edge that accepts it.
  task automatic send_req(req_t rq);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ($urandom_range(0, 9) == 0) ? 40 : 3)
                                      : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {7'd0, rq.step, rq.rate_meas, rq.angle_meas};
    // Ready only moves at a rising edge, so its mid-cycle value holds at the next one.
    @(negedge clk_i);
    while (!s_axis_tready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [kabf_pkg::NOISE_W-1:0] val);
    s_axis_tvalid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      kabf_pkg::REG_Q_ANGLE: q_angle = val;
      kabf_pkg::REG_Q_BIAS:  q_bias = val;
      kabf_pkg::REG_R_MEAS:  r_meas = val;
      default: ;
    endcase
  endtask

  // Request stimulus: directed table, then random phases under several settings.
  initial begin
    stim_row_t table_rows[$];
    stim_row_t row;
    res_t      pred;
    req_t      rq;
    filter_reset();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero step from reset leaves everything at zero apart from the rate.
    row.req = '{32'h7fff_ffff, 32'h8000_0000, 25'd0};
    row.has_known = 1'b1;
    row.known = '{32'd0, 32'd0, 32'h8000_0000};
    table_rows.push_back(row);
    row.has_known = 1'b0;
    row.req = '{32'h8000_0000, 32'h7fff_ffff, 25'h1ff_ffff};  // step clamped to one second
    table_rows.push_back(row);
    row.req = '{32'h7fff_ffff, 32'h8000_0000, kabf_pkg::ONE_SECOND};
    table_rows.push_back(row);
    row.req = '{32'h0001_0000, 32'h0000_0000, 25'(kabf_pkg::ONE_SECOND + 1)};
    table_rows.push_back(row);
    row.req = '{32'hffff_ffff, 32'h0000_0001, 25'd1};
    table_rows.push_back(row);
    row.req = '{32'h0000_0000, 32'h0000_0000, 25'd16777};
    table_rows.push_back(row);
    row.req = '{32'h5555_5555, 32'haaaa_aaaa, 25'h0aa_aaaa};
    table_rows.push_back(row);
    row.req = '{32'haaaa_aaaa, 32'h5555_5555, 25'h155_5555};
    table_rows.push_back(row);

    foreach (table_rows[i]) begin
      pred = filter_step(table_rows[i].req);
      expected_results.push_back(table_rows[i].has_known ? table_rows[i].known : pred);
      send_req(table_rows[i].req);
    end

    // Random phases; each setting is applied while the block is idle.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: begin
          write_reg(kabf_pkg::REG_R_MEAS, 31'd0);  // no measurement noise: gains may vanish
          write_reg(kabf_pkg::REG_Q_ANGLE, 31'd0);
          write_reg(kabf_pkg::REG_Q_BIAS, 31'd0);
        end
        2: begin
          write_reg(kabf_pkg::REG_R_MEAS, 31'h7fff_ffff);
          write_reg(kabf_pkg::REG_Q_ANGLE, 31'h7fff_ffff);
          write_reg(kabf_pkg::REG_Q_BIAS, 31'h7fff_ffff);
        end
        3: begin
          write_reg(kabf_pkg::REG_R_MEAS, 31'd1);
          write_reg(kabf_pkg::REG_Q_ANGLE, 31'd1);
          write_reg(kabf_pkg::REG_Q_BIAS, 31'd1);
        end
        4: begin
          write_reg(kabf_pkg::REG_R_MEAS, 31'($urandom));
          write_reg(kabf_pkg::REG_Q_ANGLE, 31'($urandom_range(0, 2_000_000)));
          write_reg(kabf_pkg::REG_Q_BIAS, 31'($urandom_range(0, 2_000_000)));
          write_reg(2'd3, 31'($urandom));  // out of range index is ignored
        end
        5: begin
          write_reg(kabf_pkg::REG_R_MEAS, kabf_pkg::R_MEAS_RST);
          write_reg(kabf_pkg::REG_Q_ANGLE, kabf_pkg::Q_ANGLE_RST);
          write_reg(kabf_pkg::REG_Q_BIAS, kabf_pkg::Q_BIAS_RST);
        end
        default: ;
      endcase
      for (int n = 0; n < N_RANDOM / 6; n++) begin
        rq = rand_req();
        expected_results.push_back(filter_step(rq));
        send_req(rq);
      end
    end
    s_axis_tvalid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // Result side: random stalls plus one long hold-off early in the run.
  initial begin
    int stall;
    @(posedge rst_ni);
    repeat (30) @(posedge clk_i);
    hold_off = 1'b1;
    m_axis_tready_i <= 1'b0;
    repeat (3000) @(posedge clk_i);
    hold_off = 1'b0;
    forever begin
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      if ($urandom_range(0, 4) == 0) begin
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 600) : $urandom_range(1, 3);
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // Check each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    res_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.angle_filt = m_axis_tdata_o[31:0];
      got.bias_est = m_axis_tdata_o[63:32];
      got.rate_corr = m_axis_tdata_o[95:64];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: angle %h/%h bias %h/%h rate %h/%h (exp/got)",
                     want.angle_filt, got.angle_filt, want.bias_est, got.bias_est,
                     want.rate_corr, got.rate_corr);
        end
      end
    end
  end

  // Cycle limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("kalman_angle_bias_filter_unit: mismatch");
      $finish;
    end
  end

  // End of run.
  initial begin
    wait (stim_done);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("kalman_angle_bias_filter_unit: match");
    end else begin
      $display("kalman_angle_bias_filter_unit: mismatch");
    end
    $finish;
  end

endmodule
